/* hdl/assert_macros.svh */
// Assertion helpers for the DNS responder checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CDQR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cdqr assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CDQR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cdqr assertion failed");

`endif

/* hdl/cdqr_pkg.sv */
// ----------------------------------------------------------------------------
// cdqr_pkg
// Shared constants, types and byte functions of the DNS A-record responder.
// ----------------------------------------------------------------------------
`default_nettype none

package cdqr_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 512;
  localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned HDR_BYTES       = 12;
  localparam int unsigned ANS_BYTES       = 16;
  localparam int unsigned ANS_IDX_W       = $clog2(ANS_BYTES);
  // last position at which the question may end and still leave room for the answer
  localparam int unsigned LAST_FIT_POS    = MAX_FRAME_BYTES - ANS_BYTES - 1;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_TTL     = 1'd1;

  localparam logic [CFG_W-1:0] TTL_RESET  = 32'd60;
  localparam logic [CFG_W-1:0] ADDR_RESET = 32'd0;

  localparam logic [7:0] FLAGS_HI    = 8'h84;
  localparam logic [7:0] PTR_HI      = 8'hC0;
  localparam logic [7:0] PTR_LO      = 8'h0C;
  localparam logic [7:0] ONE_BYTE    = 8'h01;
  localparam logic [7:0] RDLEN_LO    = 8'h04;
  localparam logic [7:0] COMPR_MASK  = 8'hC0;
  localparam logic [2:0] TAIL_BYTES  = 3'd4;

  // Work that one accepted query byte leaves for the reply side.
  typedef struct packed {
    logic       echo_v;
    logic [7:0] echo_byte;
    logic       close_ans;
    logic       close_drop;
  } action_t;

  function automatic logic [7:0] header_byte(input logic [3:0] pos, input logic [7:0] b);
    logic [7:0] r;
    case (pos)
      4'd0, 4'd1: r = b;
      4'd2:       r = FLAGS_HI | {7'd0, b[0]};
      4'd5, 4'd7: r = ONE_BYTE;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ans_byte(input logic [ANS_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] ttl,
                                          input logic [CFG_W-1:0] addr);
    logic [7:0] r;
    case (idx)
      4'd0:    r = PTR_HI;
      4'd1:    r = PTR_LO;
      4'd3:    r = ONE_BYTE;
      4'd5:    r = ONE_BYTE;
      4'd6:    r = ttl[31:24];
      4'd7:    r = ttl[23:16];
      4'd8:    r = ttl[15:8];
      4'd9:    r = ttl[7:0];
      4'd11:   r = RDLEN_LO;
      4'd12:   r = addr[31:24];
      4'd13:   r = addr[23:16];
      4'd14:   r = addr[15:8];
      4'd15:   r = addr[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/cdqr_if.sv */
// ----------------------------------------------------------------------------
// cdqr_if
// Valid/ready channels for query bytes in and reply bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdqr_query_if;
  logic       valid;
  logic       ready;
  logic [7:0] query_byte;
  logic       frame_end;

  modport source (output valid, output query_byte, output frame_end, input ready);
  modport sink   (input valid, input query_byte, input frame_end, output ready);
endinterface

interface cdqr_reply_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_end;
  logic       discard;

  modport source (output valid, output reply_byte, output reply_end, output discard,
                  input ready);
  modport sink   (input valid, input reply_byte, input reply_end, input discard,
                  output ready);
endinterface

`default_nettype wire

/* hdl/cdqr_parser.sv */
// ----------------------------------------------------------------------------
// cdqr_parser
// Per-byte header rewrite and question walk; yields one action per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cdqr_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic [7:0]        query_byte_i,
  input  wire logic              frame_end_i,
  output cdqr_pkg::action_t      action_o
);
  import cdqr_pkg::*;

  typedef enum logic [1:0] {PH_LEN, PH_LABEL, PH_TAIL, PH_DONE} phase_e;

  logic [POS_W-1:0] pos_q, pos_d;
  phase_e           phase_q, phase_d;
  logic [5:0]       label_q, label_d;
  logic [2:0]       tail_q, tail_d;
  logic             bad_q, bad_d;
  action_t          act;

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    label_d = label_q;
    tail_d  = tail_q;
    bad_d   = bad_q;
    act     = '0;

    if (pos_q >= POS_W'(MAX_FRAME_BYTES)) begin
      bad_d = 1'b1;                        // oversized: byte ignored
    end else begin
      pos_d = pos_q + POS_W'(1);
      if (!bad_q) begin
        if (pos_q < POS_W'(HDR_BYTES)) begin
          act.echo_v    = 1'b1;
          act.echo_byte = header_byte(pos_q[3:0], query_byte_i);
        end else begin
          case (phase_q)
            PH_LEN: begin
              if (query_byte_i == 8'h00) begin
                act.echo_v    = 1'b1;
                act.echo_byte = query_byte_i;
                phase_d       = PH_TAIL;
                tail_d        = TAIL_BYTES;
              end else if ((query_byte_i & COMPR_MASK) != 8'h00) begin
                bad_d = 1'b1;              // compression pointer
              end else begin
                act.echo_v    = 1'b1;
                act.echo_byte = query_byte_i;
                label_d       = query_byte_i[5:0];
                phase_d       = PH_LABEL;
              end
            end
            PH_LABEL: begin
              act.echo_v    = 1'b1;
              act.echo_byte = query_byte_i;
              label_d       = label_q - 6'd1;
              if (label_d == 6'd0) begin
                phase_d = PH_LEN;
              end
            end
            PH_TAIL: begin
              act.echo_v    = 1'b1;
              act.echo_byte = query_byte_i;
              tail_d        = tail_q - 3'd1;
              if (tail_d == 3'd0) begin
                phase_d = PH_DONE;
                if (pos_q > POS_W'(LAST_FIT_POS)) begin
                  bad_d = 1'b1;            // answer would not fit
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (frame_end_i) begin
      act.close_ans  = !bad_d && (phase_d == PH_DONE);
      act.close_drop = !act.close_ans;
      pos_d   = '0;
      phase_d = PH_LEN;
      label_d = '0;
      tail_d  = '0;
      bad_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_LEN;
      label_q <= '0;
      tail_q  <= '0;
      bad_q   <= 1'b0;
    end else if (take_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      label_q <= label_d;
      tail_q  <= tail_d;
      bad_q   <= bad_d;
    end
  end

  assign action_o = act;

endmodule

`default_nettype wire

/* hdl/captive_dns_query_responder_core.sv */
// Captive-portal DNS responder. Query bytes enter one per beat on the query
// channel; the reply leaves one byte per beat on the reply channel. Every
// query byte that gives output is echoed as one reply byte, so a query streams
// through at one byte per cycle when the reply side keeps up. The closing
// beat of a frame adds a drop marker or the sixteen-byte A-record answer;
// the answer sequencer holds off new query bytes while it runs. A query
// byte is taken in the same cycle that the last reply beat of the previous
// byte leaves, so there is no bubble between bytes.
// Configuration writes must only be issued while no reply is pending.
// ----------------------------------------------------------------------------
// captive_dns_query_responder_core
// Top level: config registers, query parser and reply beat sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module captive_dns_query_responder_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cdqr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [cdqr_pkg::CFG_W-1:0]     cfg_wdata_i,
  cdqr_query_if.sink                          query,
  cdqr_reply_if.source                        reply
);
  import cdqr_pkg::*;

  // config registers
  logic [CFG_W-1:0] addr_q, ttl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= ADDR_RESET;
      ttl_q  <= TTL_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ANSWER_ADDRESS) begin
        addr_q <= cfg_wdata_i;
      end
      if (cfg_index_i == CFG_ANSWER_TTL) begin
        ttl_q <= cfg_wdata_i;
      end
    end
  end

  // parser: state advances on every accepted query beat
  logic    take;
  action_t act;

  cdqr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .query_byte_i (query.query_byte),
    .frame_end_i  (query.frame_end),
    .action_o     (act)
  );

  // reply sequencer: echo beat first, then the close (drop or answer)
  logic                 busy_q, busy_d;
  logic                 echo_pend_q, echo_pend_d;
  logic [7:0]           echo_byte_q, echo_byte_d;
  logic                 ans_q, ans_d;
  logic                 drop_q, drop_d;
  logic [ANS_IDX_W-1:0] idx_q, idx_d;
  logic                 beat_last, beat_go, ans_last;

  assign ans_last  = (idx_q == ANS_IDX_W'(ANS_BYTES - 1));
  assign beat_last = echo_pend_q ? !(ans_q || drop_q) : (drop_q || ans_last);
  assign beat_go   = busy_q && reply.ready;

  // free, or the last beat of the held action is leaving now
  assign query.ready = !busy_q || (reply.ready && beat_last);
  assign take        = query.valid && query.ready;

  always_comb begin
    busy_d      = busy_q;
    echo_pend_d = echo_pend_q;
    echo_byte_d = echo_byte_q;
    ans_d       = ans_q;
    drop_d      = drop_q;
    idx_d       = idx_q;
    if (beat_go) begin
      if (beat_last) begin
        busy_d = 1'b0;
      end else if (echo_pend_q) begin
        echo_pend_d = 1'b0;
      end else begin
        idx_d = idx_q + ANS_IDX_W'(1);
      end
    end
    if (take && (act.echo_v || act.close_ans || act.close_drop)) begin
      busy_d      = 1'b1;
      echo_pend_d = act.echo_v;
      echo_byte_d = act.echo_byte;
      ans_d       = act.close_ans;
      drop_d      = act.close_drop;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      echo_pend_q <= 1'b0;
      ans_q       <= 1'b0;
      drop_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      echo_pend_q <= echo_pend_d;
      ans_q       <= ans_d;
      drop_q      <= drop_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    echo_byte_q <= echo_byte_d;
  end

  // beat payload straight from held state, so it is steady under back-pressure
  always_comb begin
    reply.valid      = busy_q;
    reply.reply_byte = 8'h00;
    reply.reply_end  = 1'b0;
    reply.discard    = 1'b0;
    if (echo_pend_q) begin
      reply.reply_byte = echo_byte_q;
    end else if (drop_q) begin
      reply.reply_end = 1'b1;
      reply.discard   = 1'b1;
    end else begin
      reply.reply_byte = ans_byte(idx_q, ttl_q, addr_q);
      reply.reply_end  = ans_last;
    end
  end

endmodule

`default_nettype wire

/* hdl/cdqr_checker.sv */
// ----------------------------------------------------------------------------
// cdqr_checker
// Port-level checks on the responder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cdqr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       q_valid_i,
  input wire logic       q_ready_i,
  input wire logic       q_end_i,
  input wire logic       r_valid_i,
  input wire logic       r_ready_i,
  input wire logic [7:0] r_byte_i,
  input wire logic       r_end_i,
  input wire logic       r_discard_i
);

  `CDQR_ASSERT_SAME(a_drop_shape, clk_i, rst_ni, r_valid_i && r_discard_i, r_end_i && (r_byte_i == 8'h00))
  `CDQR_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, r_valid_i && !r_ready_i, r_valid_i && $stable(r_byte_i) && $stable(r_end_i) && $stable(r_discard_i))
  `CDQR_ASSERT_SAME(a_stall_blocks_in, clk_i, rst_ni, r_valid_i && !r_ready_i, !q_ready_i)
  `CDQR_ASSERT_NEXT(a_end_gives_close, clk_i, rst_ni, q_valid_i && q_ready_i && q_end_i, r_valid_i)

endmodule

bind captive_dns_query_responder_core cdqr_checker u_cdqr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .q_valid_i   (query.valid),
  .q_ready_i   (query.ready),
  .q_end_i     (query.frame_end),
  .r_valid_i   (reply.valid),
  .r_ready_i   (reply.ready),
  .r_byte_i    (reply.reply_byte),
  .r_end_i     (reply.reply_end),
  .r_discard_i (reply.discard)
);

`default_nettype wire

/* tb/captive_dns_query_responder_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// captive_dns_query_responder_core_test
// Self-checking bench for the captive-portal DNS responder. Query frames are
// streamed in beat by beat: a short directed table first, then random frames
// that are mostly well-formed questions with random content, mixed with
// truncated, compressed, oversized and noise frames. A behavioural copy of the
// parser predicts the reply beats that the directed table does not type in,
// and each beat that leaves the block is compared with the oldest expectation.
// ----------------------------------------------------------------------------

module captive_dns_query_responder_core_test;

  import cdqr_pkg::*;

  // One reply beat as seen on the reply channel.
  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic       drop;
  } reply_beat_t;

  // Row of the directed table. n_fixed says how many beats are typed in;
  // FROM_MODEL leaves the row to the predictor.
  typedef struct {
    bit [7:0]    qbyte;
    bit          qend;
    int          n_fixed;
    reply_beat_t fixed0;
    reply_beat_t fixed1;
  } stim_row_t;

  typedef enum bit [1:0] {
    SEEK_LENGTH,
    IN_LABEL,
    IN_TAIL,
    QUESTION_DONE
  } walk_phase_e;

  localparam int          FROM_MODEL    = -1;
  localparam reply_beat_t NO_BEAT       = '0;
  localparam reply_beat_t DROP_MARK     = '{8'h00, 1'b1, 1'b1};
  localparam int          DIR_ROWS      = 31;
  localparam int          PHASE_ITEMS   = 100;
  // an answer is 16 bytes; leave room for it behind silently swallowed bytes
  localparam int          SETTLE_CYCLES = 24;
  localparam int          CYCLE_LIMIT   = 400000;

  // --------------------------------------------------------------------------
  // Clock, reset, configuration port and channels
  // --------------------------------------------------------------------------
  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  cdqr_query_if query_bus ();
  cdqr_reply_if reply_bus ();

  captive_dns_query_responder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .query       (query_bus),
    .reply       (reply_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the parser and the answer registers
  // --------------------------------------------------------------------------
  bit [9:0]    q_offset;
  walk_phase_e walk_phase;
  bit [5:0]    label_left;
  bit [2:0]    tail_left;
  bit          frame_doomed;
  bit [31:0]   reg_address;
  bit [31:0]   reg_ttl;

  reply_beat_t step_reply [$];     // beats caused by the byte just taken
  reply_beat_t pending_reply [$];  // beats still owed by the block
  bit [7:0]    frame_q [$];        // query frame being assembled

  // typed-in expectation travelling alongside the query beat
  int          fix_n;
  reply_beat_t fix0;
  reply_beat_t fix1;

  int          src_idle_pct;
  int          snk_stall_pct;
  int          mismatch_count;
  int          cycle_count;
  reply_beat_t seen_beat;
  reply_beat_t due_beat;
  stim_row_t   dir_table [DIR_ROWS];

  function automatic reply_beat_t plain_beat(input bit [7:0] b);
    reply_beat_t r;
    r = '{b, 1'b0, 1'b0};
    return r;
  endfunction

  task automatic clear_walk();
    q_offset     = '0;
    walk_phase   = SEEK_LENGTH;
    label_left   = '0;
    tail_left    = '0;
    frame_doomed = 1'b0;
  endtask

  // Works out the reply beats for one accepted query byte into step_reply.
  task automatic predict_reply(input bit [7:0] b, input bit last_byte);
    bit [9:0]   pos;
    bit [127:0] answer;
    step_reply.delete();
    if (q_offset >= MAX_FRAME_BYTES) begin
      // past the size limit: nothing echoed, frame is lost
      frame_doomed = 1'b1;
    end else begin
      pos      = q_offset;
      q_offset = q_offset + 10'd1;
      if (!frame_doomed) begin
        if (pos < HDR_BYTES) begin
          case (pos)
            0, 1:    step_reply.push_back(plain_beat(b));
            2:       step_reply.push_back(plain_beat(FLAGS_HI | {7'd0, b[0]}));
            5, 7:    step_reply.push_back(plain_beat(ONE_BYTE));
            default: step_reply.push_back(plain_beat(8'h00));
          endcase
        end else begin
          case (walk_phase)
            SEEK_LENGTH: begin
              if (b == 8'h00) begin
                step_reply.push_back(plain_beat(b));
                walk_phase = IN_TAIL;
                tail_left  = TAIL_BYTES;
              end else if ((b & COMPR_MASK) != 8'h00) begin
                frame_doomed = 1'b1;
              end else begin
                step_reply.push_back(plain_beat(b));
                label_left = b[5:0];
                walk_phase = IN_LABEL;
              end
            end
            IN_LABEL: begin
              step_reply.push_back(plain_beat(b));
              label_left = label_left - 6'd1;
              if (label_left == 6'd0) walk_phase = SEEK_LENGTH;
            end
            IN_TAIL: begin
              step_reply.push_back(plain_beat(b));
              tail_left = tail_left - 3'd1;
              if (tail_left == 3'd0) begin
                walk_phase = QUESTION_DONE;
                if (int'(pos) + 1 + int'(ANS_BYTES) > int'(MAX_FRAME_BYTES)) begin
                  frame_doomed = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
    if (last_byte) begin
      if (!frame_doomed && walk_phase == QUESTION_DONE) begin
        answer = {PTR_HI, PTR_LO, 8'h00, ONE_BYTE, 8'h00, ONE_BYTE, reg_ttl,
                  8'h00, RDLEN_LO, reg_address};
        for (int i = 0; i < int'(ANS_BYTES); i++) begin
          step_reply.push_back('{answer[127 - 8 * i -: 8], i == int'(ANS_BYTES) - 1, 1'b0});
        end
      end else begin
        step_reply.push_back(DROP_MARK);
      end
      clear_walk();
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predicts on every query beat, checks every reply beat, and
  // drives the reply-side back-pressure. Prediction comes first, ahead of the
  // check of a reply beat that leaves in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (query_bus.valid && query_bus.ready) begin
        predict_reply(query_bus.query_byte, query_bus.frame_end);
        if (fix_n == FROM_MODEL) begin
          foreach (step_reply[k]) pending_reply.push_back(step_reply[k]);
        end else begin
          if (fix_n > 0) pending_reply.push_back(fix0);
          if (fix_n > 1) pending_reply.push_back(fix1);
        end
      end
      if (reply_bus.valid && reply_bus.ready) begin
        seen_beat = '{reply_bus.reply_byte, reply_bus.reply_end, reply_bus.discard};
        if (pending_reply.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected reply beat: expected none, got byte %02h end %0b discard %0b",
                   $time, seen_beat.data, seen_beat.is_end, seen_beat.drop);
        end else begin
          due_beat = pending_reply.pop_front();
          if (seen_beat.data !== due_beat.data || seen_beat.is_end !== due_beat.is_end ||
              seen_beat.drop !== due_beat.drop) begin
            mismatch_count++;
            $display("%0t: reply mismatch: expected byte %02h end %0b discard %0b, got byte %02h end %0b discard %0b",
                     $time, due_beat.data, due_beat.is_end, due_beat.drop,
                     seen_beat.data, seen_beat.is_end, seen_beat.drop);
          end
        end
      end
      reply_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Watchdog: a hung handshake or missing beats end the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d reply beats outstanding",
             $time, cycle_count, pending_reply.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offers one query beat, with random idle cycles in front, and returns at
  // the edge where it is taken. valid gets one assignment per time step.
  task automatic send_byte(input bit [7:0] b, input bit last_byte, input int n_fixed,
                           input reply_beat_t f0, input reply_beat_t f1);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      query_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    query_bus.valid      <= 1'b1;
    query_bus.query_byte <= b;
    query_bus.frame_end  <= last_byte;
    fix_n                <= n_fixed;
    fix0                 <= f0;
    fix1                 <= f1;
    @(posedge clk_i);
    while (!query_bus.ready) @(posedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      send_byte(frame_q[i], i == frame_q.size() - 1, FROM_MODEL, NO_BEAT, NO_BEAT);
    end
  endtask

  // Holds the sender off until the block owes nothing, then lets any tail
  // of swallowed bytes and a running answer settle.
  task automatic drain_replies();
    query_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_reply.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both registers in consecutive cycles; write enable dropped once after.
  task automatic program_answer(input bit [31:0] addr, input bit [31:0] ttl);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ANSWER_ADDRESS;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_index_i <= CFG_ANSWER_TTL;
    cfg_wdata_i <= ttl;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reg_address = addr;
    reg_ttl     = ttl;
  endtask

  task automatic add_random(input int n);
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Mostly short labels, now and then any length, sometimes the longest.
  function automatic int pick_label_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 8);
    if (r < 9) return $urandom_range(1, 63);
    return 63;
  endfunction

  task automatic add_question(input int n_labels);
    int len;
    repeat (n_labels) begin
      len = pick_label_len();
      frame_q.push_back(8'(len));
      add_random(len);
    end
    frame_q.push_back(8'h00);
    add_random(4);
  endtask

  task automatic build_good_frame();
    frame_q.delete();
    add_random(HDR_BYTES);
    add_question($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) add_random($urandom_range(1, 6));
  endtask

  // Question whose last tail byte sits at offset q_end, padded to total bytes.
  task automatic build_long_frame(input int q_end, input int total);
    int rem;
    int chunk;
    frame_q.delete();
    add_random(HDR_BYTES);
    rem = q_end - 16;
    while (rem > 0) begin
      chunk = (rem > 64) ? 64 : rem;
      if (rem - chunk == 1) chunk--;   // never leave a lone zero-length label
      frame_q.push_back(8'(chunk - 1));
      add_random(chunk - 1);
      rem -= chunk;
    end
    frame_q.push_back(8'h00);
    add_random(4);
    add_random(total - frame_q.size());
  endtask

  task automatic build_random_frame();
    int       kind;
    int       cut;
    bit [7:0] ptr;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      build_good_frame();
    end else if (kind < 80) begin
      // truncated frame: ends anywhere before its natural end
      build_good_frame();
      cut = $urandom_range(1, frame_q.size() - 1);
      frame_q = frame_q[0:cut - 1];
    end else if (kind < 90) begin
      // length byte with a top bit set where a label is due
      frame_q.delete();
      add_random(HDR_BYTES);
      if ($urandom_range(0, 1) == 1) begin
        frame_q.push_back(8'd3);
        add_random(3);
      end
      ptr      = 8'($urandom_range(0, 255));
      ptr[7:6] = 2'($urandom_range(1, 3));
      frame_q.push_back(ptr);
      add_random($urandom_range(0, 5));
    end else begin
      frame_q.delete();
      add_random($urandom_range(1, 40));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_items;

    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_ANSWER_ADDRESS;
    cfg_wdata_i          = '0;
    query_bus.valid      = 1'b0;
    query_bus.query_byte = 8'h00;
    query_bus.frame_end  = 1'b0;
    reply_bus.ready      = 1'b0;
    fix_n                = FROM_MODEL;
    fix0                 = NO_BEAT;
    fix1                 = NO_BEAT;
    src_idle_pct         = 0;
    snk_stall_pct        = 0;
    mismatch_count       = 0;
    reg_address          = ADDR_RESET;
    reg_ttl              = TTL_RESET;
    clear_walk();

    // Directed rows. Most echoes and header rewrites of the first frame, and the
    // drop markers, are typed in; the rest (including the answer under the reset TTL) is predicted.
    dir_table = '{
      // lone byte: ID echoed, then dropped as short
      '{8'hFF, 1'b1, 2, plain_beat(8'hFF), DROP_MARK},
      // minimal good query with the root name
      '{8'hFF, 1'b0, 1, plain_beat(8'hFF), NO_BEAT},
      '{8'h00, 1'b0, 1, plain_beat(8'h00), NO_BEAT},
      '{8'hFE, 1'b0, 1, plain_beat(FLAGS_HI), NO_BEAT},   // RD clear, rest lost
      '{8'hFF, 1'b0, 1, plain_beat(8'h00), NO_BEAT},
      '{8'hFF, 1'b0, 1, plain_beat(8'h00), NO_BEAT},
      '{8'h00, 1'b0, 1, plain_beat(ONE_BYTE), NO_BEAT},   // QDCOUNT forced to 1
      '{8'hAA, 1'b0, 1, plain_beat(8'h00), NO_BEAT},
      '{8'h55, 1'b0, 1, plain_beat(ONE_BYTE), NO_BEAT},   // ANCOUNT forced to 1
      '{8'h80, 1'b0, 1, plain_beat(8'h00), NO_BEAT},
      '{8'h7F, 1'b0, 1, plain_beat(8'h00), NO_BEAT},
      '{8'h01, 1'b0, 1, plain_beat(8'h00), NO_BEAT},
      '{8'hFE, 1'b0, 1, plain_beat(8'h00), NO_BEAT},
      '{8'h00, 1'b0, 1, plain_beat(8'h00), NO_BEAT},      // root label
      '{8'h00, 1'b0, 1, plain_beat(8'h00), NO_BEAT},
      '{8'h01, 1'b0, 1, plain_beat(8'h01), NO_BEAT},
      '{8'h00, 1'b0, 1, plain_beat(8'h00), NO_BEAT},
      '{8'h01, 1'b1, FROM_MODEL, NO_BEAT, NO_BEAT},       // last tail byte + answer
      // compression pointer where the first label length belongs
      '{8'h12, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h34, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h01, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h01, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, FROM_MODEL, NO_BEAT, NO_BEAT},
      '{8'hC0, 1'b1, 1, DROP_MARK, NO_BEAT}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) begin
      send_byte(dir_table[i].qbyte, dir_table[i].qend, dir_table[i].n_fixed,
                dir_table[i].fixed0, dir_table[i].fixed1);
    end
    drain_replies();

    // Random part in four idling phases, each under its own answer settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
          program_answer(32'hFFFF_FFFF, 32'h0000_0000);
        end
        1: begin
          src_idle_pct  = 57;
          snk_stall_pct = 0;
          program_answer(32'h0000_0000, 32'hFFFF_FFFF);
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 57;
          program_answer($urandom, $urandom);
        end
        default: begin
          src_idle_pct  = 6;
          snk_stall_pct = 6;
          program_answer($urandom, $urandom);
        end
      endcase

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_random_frame();
        send_frame();
        phase_items += frame_q.size();
        // now and then let the reply side run dry mid-phase
        if ($urandom_range(0, 19) == 0) drain_replies();
      end

      if (ph == 0) begin
        // question ends on the last offset that still fits the answer,
        // frame exactly at the size limit
        build_long_frame(int'(LAST_FIT_POS), int'(MAX_FRAME_BYTES));
        send_frame();
        // one offset later: answer would overflow, dropped
        build_long_frame(int'(LAST_FIT_POS) + 1, int'(LAST_FIT_POS) + 2);
        send_frame();
      end
      if (ph == 3) begin
        // good question, then padding past the limit; end lands on an ignored byte
        build_long_frame($urandom_range(18, 80), int'(MAX_FRAME_BYTES) + 8);
        send_frame();
      end

      drain_replies();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
